/* sv/crc16_byte_stuffed_frame_encoder_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the crc16 byte-stuffed frame encoder
// Concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CRC16_BYTE_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH
`define CRC16_BYTE_STUFFED_FRAME_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold on every clock edge out of reset
`define CBSFE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define CBSFE_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CBSFE_ASSERT(label, clk, rst_n, prop, msg)
`define CBSFE_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* sv/cbsfe_pkg.sv */
// ----------------------------------------------------------------------------
// cbsfe_pkg
// Types, constants and helper functions shared by the frame encoder modules
// ----------------------------------------------------------------------------
package cbsfe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIRECTION  = 2'd0,
        REG_DEVICE_ID  = 2'd1,
        REG_FRAME_HEAD = 2'd2,
        REG_FRAME_TAIL = 2'd3
    } cfg_reg_t;

    localparam logic       DIR_ENCODE = 1'b0;
    localparam logic       KIND_START = 1'b0;
    localparam logic       KIND_DATA  = 1'b1;

    localparam logic [7:0]  ESC_BYTE   = 8'h7D;
    localparam logic [7:0]  ESC_FLIP   = 8'h20;
    localparam logic [7:0]  FLAG_TAIL  = 8'h7E;
    localparam logic [7:0]  FLAG_HEAD  = 8'h7F;
    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] CRC_TOP    = 16'h8000;

    typedef struct packed {
        logic        direction;
        logic [15:0] device_id;
        logic [7:0]  frame_head;
        logic [7:0]  frame_tail;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] command_word;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        logic        end_of_block;
    } item_t;

    // position of the raw byte within the current item
    typedef enum logic [9:0] {
        PH_FIRST  = 10'b00_0000_0001,
        PH_C0     = 10'b00_0000_0010,
        PH_C1     = 10'b00_0000_0100,
        PH_D0     = 10'b00_0000_1000,
        PH_D1     = 10'b00_0001_0000,
        PH_L0     = 10'b00_0010_0000,
        PH_L1     = 10'b00_0100_0000,
        PH_CRC_LO = 10'b00_1000_0000,
        PH_CRC_HI = 10'b01_0000_0000,
        PH_TAIL   = 10'b10_0000_0000
    } phase_t;

    // one byte of crc-16 poly 0x8005, msb first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == FLAG_TAIL) || (b == FLAG_HEAD);
    endfunction

endpackage

/* sv/crc16_byte_stuffed_frame_encoder_top.sv */
// ----------------------------------------------------------------------------
// crc16_byte_stuffed_frame_encoder_top
// Serial command framer with crc-16 and byte stuffing, plus escape removal
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel. In encode mode a start item (tuser 0)
// opens a frame: head, command word, device id and length go out low byte
// first, then each data item (tuser 1) adds one payload byte. After the last
// payload byte the crc (low byte first) and the tail byte follow, the tail
// with tlast set. Bytes between head and tail equal to 0x7D..0x7F go out as
// 0x7D and the byte xor 0x20. In decode mode the escapes are only removed and
// tlast of the input is passed to the byte it ends.
// Results leave on the m_ channel, one byte per cycle unless the receiver
// stalls, from an output register; the first byte of an item passes the
// input register and then the output register. An item stays in the input
// register until it has given all its output bytes: one or two for a data
// byte, 4 to 7 for the data byte that closes the frame, 7 to 18 for a start
// item. A decode item, or a data item with no frame open, gives one byte or
// none. The next item is taken in the cycle the held one finishes, so bytes
// stream without bubbles except where an item gives no byte.
// When the receiver stalls, the output byte holds and the input stops taking
// items once the held item has a byte ready. Reset clears the frame state and
// loads the register defaults; no clearing pass is needed. Configuration
// writes take effect on the next edge; the user keeps them to idle, unchecked.
// ----------------------------------------------------------------------------
module crc16_byte_stuffed_frame_encoder_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // command_word [15:0], payload_length [31:16], payload_byte [39:32]
    input  logic [cbsfe_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_byte [7:0]
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [cbsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbsfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import cbsfe_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  pop;

    cbsfe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    cbsfe_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .pop        (pop),
        .item       (item),
        .item_valid (item_valid)
    );

    cbsfe_framer u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .item_valid (item_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

/* sv/cbsfe_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cbsfe_cfg_regs
// Configuration register file written through a plain write port
// ----------------------------------------------------------------------------
module cbsfe_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cbsfe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbsfe_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output cbsfe_pkg::cfg_t                   cfg
);
    import cbsfe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIRECTION:  cfg_next.direction  = cfg_wdata[0];
                REG_DEVICE_ID:  cfg_next.device_id  = cfg_wdata[15:0];
                REG_FRAME_HEAD: cfg_next.frame_head = cfg_wdata[7:0];
                REG_FRAME_TAIL: cfg_next.frame_tail = cfg_wdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction  <= DIR_ENCODE;
            cfg_reg.device_id  <= 16'h0000;
            cfg_reg.frame_head <= FLAG_HEAD;
            cfg_reg.frame_tail <= FLAG_TAIL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/cbsfe_in_reg.sv */
// ----------------------------------------------------------------------------
// cbsfe_in_reg
// Input register holding the item that the framer is working on
// ----------------------------------------------------------------------------
module cbsfe_in_reg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cbsfe_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               pop,
    output cbsfe_pkg::item_t                   item,
    output logic                               item_valid
);
    import cbsfe_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  valid_reg;
    logic  valid_next;
    logic  load;

    // a new item may enter in the cycle the held one is finished
    assign s_tready = !valid_reg || pop;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        item_next.kind           = s_tuser;
        item_next.command_word   = s_tdata[15:0];
        item_next.payload_length = s_tdata[31:16];
        item_next.payload_byte   = s_tdata[39:32];
        item_next.end_of_block   = s_tlast;

        if (load)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

/* sv/cbsfe_framer.sv */
// ----------------------------------------------------------------------------
// cbsfe_framer
// Walks the raw bytes of the held item, runs the crc, stuffs escapes (or
// removes them in decode mode) and drives the output register
// ----------------------------------------------------------------------------
`include "crc16_byte_stuffed_frame_encoder_top_assert.svh"

module cbsfe_framer (
    input  logic              clk,
    input  logic              rst_n,
    input  cbsfe_pkg::cfg_t   cfg,
    input  cbsfe_pkg::item_t  item,
    input  logic              item_valid,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // out_byte
    output logic              m_tlast
);
    import cbsfe_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        half_reg, half_next;
    logic        frame_open_reg, frame_open_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] crc_reg, crc_next;
    logic        esc_pending_reg, esc_pending_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;

    logic        slot;
    logic        emit;
    logic [7:0]  emit_byte;
    logic        emit_last;
    logic        advance;
    logic [7:0]  raw_byte;
    logic        escapable;
    logic [15:0] crc_step;

    assign slot = !out_valid_reg || m_tready;

    always_comb
    begin
        unique case (phase_reg)
            PH_FIRST:  raw_byte = (item.kind == KIND_START) ? cfg.frame_head : item.payload_byte;
            PH_C0:     raw_byte = item.command_word[7:0];
            PH_C1:     raw_byte = item.command_word[15:8];
            PH_D0:     raw_byte = cfg.device_id[7:0];
            PH_D1:     raw_byte = cfg.device_id[15:8];
            PH_L0:     raw_byte = item.payload_length[7:0];
            PH_L1:     raw_byte = item.payload_length[15:8];
            PH_CRC_LO: raw_byte = crc_reg[7:0];
            PH_CRC_HI: raw_byte = crc_reg[15:8];
            PH_TAIL:   raw_byte = cfg.frame_tail;
            default:   raw_byte = item.payload_byte;
        endcase
    end

    // head and tail go out raw
    assign escapable = !((phase_reg == PH_TAIL) ||
                         ((phase_reg == PH_FIRST) && (item.kind == KIND_START)));
    assign crc_step  = crc16_byte(crc_reg, raw_byte);

    always_comb
    begin
        phase_next       = phase_reg;
        half_next        = half_reg;
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        crc_next         = crc_reg;
        esc_pending_next = esc_pending_reg;
        pop              = 1'b0;
        emit             = 1'b0;
        emit_byte        = raw_byte;
        emit_last        = 1'b0;
        advance          = 1'b0;

        if (item_valid)
        begin
            if (cfg.direction != DIR_ENCODE)
            begin
                if (esc_pending_reg)
                begin
                    if (slot)
                    begin
                        emit             = 1'b1;
                        emit_byte        = item.payload_byte ^ ESC_FLIP;
                        emit_last        = item.end_of_block;
                        esc_pending_next = 1'b0;
                        pop              = 1'b1;
                    end
                end
                else if (item.payload_byte == ESC_BYTE)
                begin
                    // escape on the last byte of a block is dropped
                    esc_pending_next = !item.end_of_block;
                    pop              = 1'b1;
                end
                else if (slot)
                begin
                    emit      = 1'b1;
                    emit_byte = item.payload_byte;
                    emit_last = item.end_of_block;
                    pop       = 1'b1;
                end
            end
            else if ((phase_reg == PH_FIRST) && (item.kind == KIND_DATA) && !frame_open_reg)
            begin
                pop = 1'b1;
            end
            else if (slot)
            begin
                emit = 1'b1;
                if (escapable && needs_escape(raw_byte) && !half_reg)
                begin
                    emit_byte = ESC_BYTE;
                    half_next = 1'b1;
                end
                else
                begin
                    emit_byte = half_reg ? (raw_byte ^ ESC_FLIP) : raw_byte;
                    half_next = 1'b0;
                    advance   = 1'b1;
                end
            end
        end

        if (advance)
        begin
            unique case (phase_reg)
                PH_FIRST:
                begin
                    if (item.kind == KIND_START)
                    begin
                        frame_open_next = 1'b1;
                        bytes_left_next = item.payload_length;
                        crc_next        = 16'h0000;
                        phase_next      = PH_C0;
                    end
                    else
                    begin
                        crc_next        = crc_step;
                        bytes_left_next = bytes_left_reg - 16'd1;
                        if (bytes_left_reg == 16'd1)
                            phase_next = PH_CRC_LO;
                        else
                            pop = 1'b1;
                    end
                end
                PH_C0:
                begin
                    crc_next   = crc_step;
                    phase_next = PH_C1;
                end
                PH_C1:
                begin
                    crc_next   = crc_step;
                    phase_next = PH_D0;
                end
                PH_D0:
                begin
                    crc_next   = crc_step;
                    phase_next = PH_D1;
                end
                PH_D1:
                begin
                    crc_next   = crc_step;
                    phase_next = PH_L0;
                end
                PH_L0:
                begin
                    crc_next   = crc_step;
                    phase_next = PH_L1;
                end
                PH_L1:
                begin
                    crc_next = crc_step;
                    // empty payload closes the frame right away
                    if (item.payload_length == 16'd0)
                        phase_next = PH_CRC_LO;
                    else
                        pop = 1'b1;
                end
                PH_CRC_LO: phase_next = PH_CRC_HI;
                PH_CRC_HI: phase_next = PH_TAIL;
                PH_TAIL:
                begin
                    emit_last       = 1'b1;
                    frame_open_next = 1'b0;
                    bytes_left_next = 16'd0;
                    crc_next        = 16'h0000;
                    pop             = 1'b1;
                end
                default: phase_next = PH_FIRST;
            endcase
        end

        if (pop)
        begin
            phase_next = PH_FIRST;
            half_next  = 1'b0;
        end

        if (emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FIRST;
            half_reg        <= 1'b0;
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 16'd0;
            crc_reg         <= 16'h0000;
            esc_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            half_reg        <= half_next;
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            crc_reg         <= crc_next;
            esc_pending_reg <= esc_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    `CBSFE_ASSERT(a_half_needs_item, clk, rst_n, half_reg |-> item_valid, "escape half pending with no item held")
    `CBSFE_ASSERT(a_phase_needs_item, clk, rst_n, (phase_reg != PH_FIRST) |-> item_valid, "frame walk in progress with no item held")
    `CBSFE_ASSERT(a_open_has_count, clk, rst_n, (frame_open_reg && (phase_reg == PH_FIRST)) |-> (bytes_left_reg != 16'd0), "open frame waiting with zero bytes left")
    `CBSFE_ASSERT(a_tail_is_last, clk, rst_n, (emit && advance && (phase_reg == PH_TAIL)) |=> (out_valid_reg && out_last_reg), "tail byte not marked last")
    `CBSFE_NEVER(a_no_overwrite, clk, rst_n, emit && out_valid_reg && !m_tready, "output register overwritten while stalled")

endmodule
